// ----- hw/rtl/cfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfe_pkg: shared types and constants of the ccTalk frame engine
// Transfer types, function and status codes, and the frame geometry used by
// the front end, the result queue and the top level.
// ----------------------------------------------------------------------------
package cfe_pkg;

    // Frame geometry.
    localparam int FRAME_DEPTH     = 64;
    localparam int CNT_W           = $clog2(FRAME_DEPTH) + 1;
    localparam int ADDR_W          = $clog2(FRAME_DEPTH);
    localparam int ROW_W           = ADDR_W - 1;
    localparam int BANK_DEPTH      = FRAME_DEPTH / 2;
    localparam int LEN_W           = 6;
    localparam logic [7:0] DATA_LIMIT      = 8'd58;
    localparam logic [6:0] ANSWER_OVERHEAD = 7'd5;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Input function codes.
    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_SEND    = 2'd1;
    localparam logic [1:0] FUNC_RECV    = 2'd2;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd3;

    // Receive phase codes.
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_ECHO     = 2'd1;
    localparam logic [1:0] PH_ANSWER   = 2'd2;
    localparam logic [1:0] PH_COMPLETE = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_WRONG_ECHO = 3'd1;
    localparam logic [2:0] ERR_NO_ECHO    = 3'd2;
    localparam logic [2:0] ERR_LENGTH     = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM   = 3'd4;
    localparam logic [2:0] ERR_ANS_TMO    = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_SOURCE_ADDRESS  = 1'b0;
    localparam logic CFG_MAX_DATA_LENGTH = 1'b1;

    // Register reset values.
    localparam logic [7:0]       SOURCE_ADDRESS_RST  = 8'd1;
    localparam logic [LEN_W-1:0] MAX_DATA_LENGTH_RST = 6'd58;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       send_last;
    } t_in_item;

    typedef struct packed {
        logic             line_valid;
        logic [7:0]       line_byte;
        logic             answer_valid;
        logic [7:0]       answer_byte;
        logic [LEN_W-1:0] answer_index;
        logic [1:0]       rx_state;
        logic [2:0]       error_code;
        logic             last;
    } t_out_item;

    // One or two results produced by the front end for one accepted item.
    typedef struct packed {
        logic      valid;
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_push;

endpackage : cfe_pkg
`default_nettype wire

// ----- hw/rtl/cfe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfe_front: request builder, echo checker and answer checker
// Holds the configuration registers, the frame state and the echo store. It
// handles one accepted item per cycle and hands one or two results onward.
// ----------------------------------------------------------------------------
module cfe_front import cfe_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_fire,
    input  wire t_in_item    i_in,
    output t_push            o_push
);

    // Configuration registers.
    logic [7:0]       r_source_address;
    logic [LEN_W-1:0] r_max_data_length;

    // Frame state.
    logic [1:0]       r_phase, n_phase;
    logic [2:0]       r_error, n_error;
    logic [CNT_W-1:0] r_sent_count, n_sent_count;
    logic [7:0]       r_send_sum, n_send_sum;
    logic [CNT_W-1:0] r_echo_count, n_echo_count;
    logic             r_echo_mismatch, n_echo_mismatch;
    logic             r_tx_closed, n_tx_closed;
    logic [LEN_W-1:0] r_answer_count, n_answer_count;
    logic [7:0]       r_answer_sum, n_answer_sum;
    logic [LEN_W-1:0] r_answer_length, n_answer_length;

    // Echo store, split into even and odd banks so two bytes can be written.
    logic [7:0] r_bank_even [BANK_DEPTH];
    logic [7:0] r_bank_odd  [BANK_DEPTH];
    logic [7:0] r_echo_rd;

    logic [1:0]        tx_num;
    logic [7:0]        tx_byte0, tx_byte1;
    logic              ans;
    logic [7:0]        limit;
    logic              after_len;
    logic              need_two;
    logic              has_room;
    logic [7:0]        echo_rd;
    logic [ADDR_W-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_row;
    logic [ADDR_W-1:0] wr_addr0, wr_addr1;
    logic              wr_en0, wr_en1;
    logic              even_en, odd_en;
    logic [ROW_W-1:0]  even_row, odd_row;
    logic [7:0]        even_data, odd_data;
    logic [CNT_W-1:0]  echo_inc;
    logic [6:0]        answer_inc;
    logic [6:0]        answer_target;
    t_out_item         res0, res1;

    // Effective answer data length limit.
    assign limit = ({2'b00, r_max_data_length} > DATA_LIMIT) ? DATA_LIMIT
                                                              : {2'b00, r_max_data_length};

    // Send-side room check: the length byte and the final byte each take two slots.
    assign after_len = (r_sent_count == CNT_W'(1));
    assign need_two  = after_len || i_in.send_last;
    assign has_room  = need_two ? (r_sent_count <= CNT_W'(FRAME_DEPTH - 2))
                                : (r_sent_count <= CNT_W'(FRAME_DEPTH - 1));

    // The echo store byte at the next position to be compared, registered ahead
    // of its use.
    assign echo_rd = r_echo_rd;
    assign rd_addr = i_in_fire ? n_echo_count[ADDR_W-1:0] : r_echo_count[ADDR_W-1:0];
    assign rd_row  = rd_addr[ADDR_W-1:1];

    assign echo_inc      = r_echo_count + CNT_W'(1);
    assign answer_inc    = {1'b0, r_answer_count} + 7'd1;
    assign answer_target = {1'b0, n_answer_length} + ANSWER_OVERHEAD;

    // Next-state logic for one accepted item.
    always_comb begin
        n_phase         = r_phase;
        n_error         = r_error;
        n_sent_count    = r_sent_count;
        n_send_sum      = r_send_sum;
        n_echo_count    = r_echo_count;
        n_echo_mismatch = r_echo_mismatch;
        n_tx_closed     = r_tx_closed;
        n_answer_count  = r_answer_count;
        n_answer_sum    = r_answer_sum;
        n_answer_length = r_answer_length;
        tx_num          = 2'd0;
        tx_byte0        = 8'd0;
        tx_byte1        = 8'd0;
        ans             = 1'b0;
        case (i_in.func)
            FUNC_START: begin
                n_phase         = PH_ECHO;
                n_error         = ERR_NONE;
                n_sent_count    = '0;
                n_send_sum      = 8'd0;
                n_echo_count    = '0;
                n_echo_mismatch = 1'b0;
                n_tx_closed     = 1'b0;
                n_answer_count  = '0;
                n_answer_sum    = 8'd0;
                n_answer_length = '0;
            end
            FUNC_SEND: begin
                if (r_phase == PH_ECHO && r_error == ERR_NONE && !r_tx_closed && has_room) begin
                    tx_byte0 = i_in.data_byte;
                    tx_num   = 2'd1;
                    if (i_in.send_last) begin
                        tx_byte1    = 8'd0 - (r_send_sum + i_in.data_byte);
                        tx_num      = 2'd2;
                        n_tx_closed = 1'b1;
                    end else if (after_len) begin
                        tx_byte1 = r_source_address;
                        tx_num   = 2'd2;
                    end
                    n_send_sum   = r_send_sum + tx_byte0 + tx_byte1;
                    n_sent_count = r_sent_count + CNT_W'(tx_num);
                end
            end
            FUNC_RECV: begin
                if (r_error == ERR_NONE && r_phase == PH_ECHO) begin
                    if (r_echo_count < r_sent_count) begin
                        n_echo_mismatch = r_echo_mismatch || (echo_rd != i_in.data_byte);
                        n_echo_count    = echo_inc;
                        if (r_tx_closed && echo_inc == r_sent_count) begin
                            if (n_echo_mismatch) begin
                                n_error = ERR_WRONG_ECHO;
                            end else begin
                                n_phase = PH_ANSWER;
                            end
                        end
                    end else begin
                        n_error = ERR_WRONG_ECHO;
                    end
                end else if (r_error == ERR_NONE && r_phase == PH_ANSWER) begin
                    ans          = 1'b1;
                    n_answer_sum = r_answer_sum + i_in.data_byte;
                    if (r_answer_count == LEN_W'(1)) begin
                        n_answer_length = i_in.data_byte[LEN_W-1:0];
                        if (i_in.data_byte > limit) begin
                            n_error = ERR_LENGTH;
                        end
                    end
                    n_answer_count = answer_inc[LEN_W-1:0];
                    if (n_error == ERR_NONE && answer_inc >= 7'd2
                            && answer_inc == answer_target) begin
                        if (n_answer_sum != 8'd0) begin
                            n_error = ERR_CHECKSUM;
                        end else begin
                            n_phase = PH_COMPLETE;
                        end
                    end
                end
            end
            FUNC_TIMEOUT: begin
                if (r_error == ERR_NONE && r_phase == PH_ECHO) begin
                    n_error = ERR_NO_ECHO;
                end else if (r_error == ERR_NONE && r_phase == PH_ANSWER) begin
                    n_error = ERR_ANS_TMO;
                end
            end
            default: begin
            end
        endcase
    end

    // Echo store write steering: the two bytes always land in different banks.
    assign wr_addr0 = r_sent_count[ADDR_W-1:0];
    assign wr_addr1 = wr_addr0 + ADDR_W'(1);
    assign wr_en0   = i_in_fire && (tx_num != 2'd0);
    assign wr_en1   = i_in_fire && (tx_num == 2'd2);

    always_comb begin
        even_en   = 1'b0;
        even_row  = wr_addr0[ADDR_W-1:1];
        even_data = tx_byte0;
        odd_en    = 1'b0;
        odd_row   = wr_addr0[ADDR_W-1:1];
        odd_data  = tx_byte0;
        if (!wr_addr0[0]) begin
            even_en  = wr_en0;
            odd_en   = wr_en1;
            odd_row  = wr_addr1[ADDR_W-1:1];
            odd_data = tx_byte1;
        end else begin
            odd_en    = wr_en0;
            even_en   = wr_en1;
            even_row  = wr_addr1[ADDR_W-1:1];
            even_data = tx_byte1;
        end
    end

    // Echo store writes, and the registered read of the next byte to compare.
    // A byte written at the position being read is passed straight through.
    always_ff @(posedge i_clk) begin
        if (even_en) begin
            r_bank_even[even_row] <= even_data;
        end
        if (odd_en) begin
            r_bank_odd[odd_row] <= odd_data;
        end
        if (rd_addr[0]) begin
            if (odd_en && odd_row == rd_row) begin
                r_echo_rd <= odd_data;
            end else begin
                r_echo_rd <= r_bank_odd[rd_row];
            end
        end else begin
            if (even_en && even_row == rd_row) begin
                r_echo_rd <= even_data;
            end else begin
                r_echo_rd <= r_bank_even[rd_row];
            end
        end
    end

    // Configuration and frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_address  <= SOURCE_ADDRESS_RST;
            r_max_data_length <= MAX_DATA_LENGTH_RST;
            r_phase           <= PH_IDLE;
            r_error           <= ERR_NONE;
            r_sent_count      <= '0;
            r_send_sum        <= 8'd0;
            r_echo_count      <= '0;
            r_echo_mismatch   <= 1'b0;
            r_tx_closed       <= 1'b0;
            r_answer_count    <= '0;
            r_answer_sum      <= 8'd0;
            r_answer_length   <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SOURCE_ADDRESS) begin
                    r_source_address <= i_cfg_data;
                end else begin
                    r_max_data_length <= i_cfg_data[LEN_W-1:0];
                end
            end
            if (i_in_fire) begin
                r_phase         <= n_phase;
                r_error         <= n_error;
                r_sent_count    <= n_sent_count;
                r_send_sum      <= n_send_sum;
                r_echo_count    <= n_echo_count;
                r_echo_mismatch <= n_echo_mismatch;
                r_tx_closed     <= n_tx_closed;
                r_answer_count  <= n_answer_count;
                r_answer_sum    <= n_answer_sum;
                r_answer_length <= n_answer_length;
            end
        end
    end

    // Result assembly: line bytes take priority, then an answer byte, else status only.
    always_comb begin
        res0              = '0;
        res0.rx_state     = n_phase;
        res0.error_code   = n_error;
        res0.last         = (tx_num != 2'd2);
        if (tx_num != 2'd0) begin
            res0.line_valid = 1'b1;
            res0.line_byte  = tx_byte0;
        end else if (ans) begin
            res0.answer_valid = 1'b1;
            res0.answer_byte  = i_in.data_byte;
            res0.answer_index = r_answer_count;
        end
        res1            = '0;
        res1.line_valid = 1'b1;
        res1.line_byte  = tx_byte1;
        res1.rx_state   = n_phase;
        res1.error_code = n_error;
        res1.last       = 1'b1;
    end

    assign o_push.valid  = i_in_fire;
    assign o_push.two    = (tx_num == 2'd2);
    assign o_push.first  = res0;
    assign o_push.second = res1;

endmodule : cfe_front
`default_nettype wire

// ----- hw/rtl/cfe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfe_queue: result queue between the front end and the output channel
// Takes one or two results per cycle and presents them one per transfer on
// the output channel. It stalls the input while fewer than two slots are free.
// ----------------------------------------------------------------------------
module cfe_queue import cfe_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_push     i_push,
    output logic           o_full,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    t_out_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic [QCNT_W-1:0]  push_num;
    logic               pop;
    logic [QPTR_W-1:0]  wr_ptr1;

    assign push_num = !i_push.valid ? QCNT_W'(0)
                    : (i_push.two ? QCNT_W'(2) : QCNT_W'(1));
    assign pop      = (r_count != '0) && !i_out_stall;
    assign wr_ptr1  = r_wr_ptr + QPTR_W'(1);

    assign n_wr_ptr = r_wr_ptr + push_num[QPTR_W-1:0];
    assign n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
    assign n_count  = r_count + push_num - QCNT_W'(pop);

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.first;
            if (i_push.two) begin
                r_mem[wr_ptr1] <= i_push.second;
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_full      = (r_count > QCNT_W'(QUEUE_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out       = r_mem[r_rd_ptr];

endmodule : cfe_queue
`default_nettype wire

// ----- hw/rtl/cctalk_frame_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cctalk_frame_engine_unit: host-side ccTalk frame engine, byte level
// Builds request frames with source address and checksum, checks the echo
// of each request and checks the length and checksum of the answer.
// ----------------------------------------------------------------------------
// The engine accepts one item per clock cycle: the front end updates all
// counters, running sums and the echo store at once, so the input is taken
// every cycle as long as the result queue has two free slots. Each item
// yields one result, or two when a send byte puts a second byte on the line
// (source address after the length byte, checksum after the last byte); the
// output channel drains one result per transfer, so a run of two-result
// items cannot be taken every cycle. Results are held in a four-entry queue,
// and the input stalls only while fewer than two slots are free or while
// reset is asserted. Configuration writes are accepted in every cycle out of
// reset and take effect on the next cycle.
module cctalk_frame_engine_unit import cfe_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out
);

    logic  in_fire;
    logic  queue_full;
    t_push push;

    // Input transfer happens out of reset when the queue can take two results.
    assign o_in_stall  = !i_rst_n || queue_full;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = i_rst_n;

    cfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_fire   (in_fire),
        .i_in        (i_in),
        .o_push      (push)
    );

    cfe_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (queue_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule : cctalk_frame_engine_unit
`default_nettype wire

// ----- dv/cctalk_frame_engine_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cctalk_frame_engine_unit_tb: self-checking bench for the ccTalk frame engine
// Drives request frames, echoes and answers into the engine, predicts every
// line byte, answer byte and status result in the bench itself, and checks
// each output transfer in order against that prediction under random idling
// on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module cctalk_frame_engine_unit_tb;
    import cfe_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 3000;

    // Clock, reset and block inputs, all known from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in        = '0;
    logic       i_out_stall = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out;

    // Idling controls and run bookkeeping.
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;
    int         items_sent   = 0;
    int         mismatches   = 0;
    int         stuck_cycles = 0;
    logic       hold_req     = 1'b0;
    logic       hold_ack     = 1'b0;
    int         hold_left    = 0;

    // Predicted engine state and register copies.
    logic [7:0]       m_src;
    logic [LEN_W-1:0] m_max_len;
    logic [1:0]       m_phase;
    logic [2:0]       m_err;
    int               m_sent;
    logic [7:0]       m_tx_sum;
    int               m_echo;
    logic             m_echo_bad;
    logic [7:0]       m_echo_mem [FRAME_DEPTH];
    int               m_ans_n;
    logic [7:0]       m_ans_sum;
    logic [7:0]       m_ans_len;
    logic             m_closed;

    // Results still owed by the engine, oldest first.
    t_out_item  frame_results_q [$];
    t_out_item  want_item;

    cctalk_frame_engine_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Free-running clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Clear all frame state, as a start item does.
    function automatic void clear_engine();
        m_phase    = PH_IDLE;
        m_err      = ERR_NONE;
        m_sent     = 0;
        m_tx_sum   = 8'h00;
        m_echo     = 0;
        m_echo_bad = 1'b0;
        m_ans_n    = 0;
        m_ans_sum  = 8'h00;
        m_ans_len  = 8'h00;
        m_closed   = 1'b0;
        for (int k = 0; k < FRAME_DEPTH; k++) m_echo_mem[k] = 8'h00;
    endfunction

    // Advance the predicted engine by one accepted item and queue its results.
    function automatic void compute_frame_results(t_in_item it);
        logic [7:0] tx [2];
        int         tx_n;
        logic       ans_ok;
        logic [7:0] ans_b;
        int         ans_i;
        logic       after_len;
        int         need;
        int         lim;
        int         k;
        t_out_item  r;
        tx_n   = 0;
        ans_ok = 1'b0;
        ans_b  = 8'h00;
        ans_i  = 0;
        case (it.func)
            FUNC_START: begin
                clear_engine();
                m_phase = PH_ECHO;
            end
            FUNC_SEND: begin
                if (m_phase == PH_ECHO && m_err == ERR_NONE && !m_closed) begin
                    after_len = (m_sent == 1);
                    need      = (after_len || it.send_last) ? 2 : 1;
                    if (FRAME_DEPTH - m_sent >= need) begin
                        tx[0] = it.data_byte;
                        tx_n  = 1;
                        // The checksum wins over the source when the length byte is last.
                        if (it.send_last) begin
                            tx[1]    = 8'h00 - (m_tx_sum + it.data_byte);
                            tx_n     = 2;
                            m_closed = 1'b1;
                        end else if (after_len) begin
                            tx[1] = m_src;
                            tx_n  = 2;
                        end
                        for (k = 0; k < tx_n; k++) begin
                            if (m_sent < FRAME_DEPTH) begin
                                m_echo_mem[m_sent] = tx[k];
                                m_sent++;
                            end
                            m_tx_sum = m_tx_sum + tx[k];
                        end
                    end
                end
            end
            FUNC_RECV: begin
                if (m_err == ERR_NONE && m_phase == PH_ECHO) begin
                    // Echo check; a byte with nothing outstanding fails at once.
                    if (m_echo < m_sent && m_echo < FRAME_DEPTH) begin
                        if (m_echo_mem[m_echo] != it.data_byte) m_echo_bad = 1'b1;
                        m_echo++;
                        if (m_closed && m_echo == m_sent) begin
                            if (m_echo_bad) m_err = ERR_WRONG_ECHO;
                            else m_phase = PH_ANSWER;
                        end
                    end else begin
                        m_err = ERR_WRONG_ECHO;
                    end
                end else if (m_err == ERR_NONE && m_phase == PH_ANSWER) begin
                    lim       = (m_max_len > DATA_LIMIT) ? int'(DATA_LIMIT) : int'(m_max_len);
                    ans_ok    = 1'b1;
                    ans_b     = it.data_byte;
                    ans_i     = m_ans_n;
                    m_ans_sum = m_ans_sum + it.data_byte;
                    if (m_ans_n == 1) begin
                        m_ans_len = it.data_byte;
                        if (int'(it.data_byte) > lim) m_err = ERR_LENGTH;
                    end
                    m_ans_n++;
                    if (m_err == ERR_NONE && m_ans_n >= 2 &&
                        m_ans_n == int'(m_ans_len) + int'(ANSWER_OVERHEAD)) begin
                        if (m_ans_sum != 8'h00) m_err = ERR_CHECKSUM;
                        else m_phase = PH_COMPLETE;
                    end
                end
            end
            default: begin
                if (m_err == ERR_NONE && m_phase == PH_ECHO) m_err = ERR_NO_ECHO;
                else if (m_err == ERR_NONE && m_phase == PH_ANSWER) m_err = ERR_ANS_TMO;
            end
        endcase

        // Line bytes take precedence; otherwise an answer byte or a status result.
        if (tx_n > 0) begin
            for (k = 0; k < tx_n; k++) begin
                r            = '0;
                r.line_valid = 1'b1;
                r.line_byte  = tx[k];
                r.rx_state   = m_phase;
                r.error_code = m_err;
                r.last       = (k == tx_n - 1);
                frame_results_q.push_back(r);
            end
        end else begin
            r = '0;
            if (ans_ok) begin
                r.answer_valid = 1'b1;
                r.answer_byte  = ans_b;
                r.answer_index = LEN_W'(ans_i);
            end
            r.rx_state   = m_phase;
            r.error_code = m_err;
            r.last       = 1'b1;
            frame_results_q.push_back(r);
        end
    endfunction

    function automatic t_in_item make_item(logic [1:0] f, logic [7:0] d, logic l);
        t_in_item it;
        it.func      = f;
        it.data_byte = d;
        it.send_last = l;
        return it;
    endfunction

    // Offer one item, with random idle cycles ahead of it, and wait for its transfer.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        compute_frame_results(it);
        items_sent++;
    endtask

    // Drop the input and wait until every predicted result has been transferred.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_SOURCE_ADDRESS) m_src = val;
        else m_max_len = val[LEN_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One exchange: start, request, echo and answer, sometimes broken on purpose.
    task automatic run_exchange(bit allow_flaws);
        int         flaw;
        int         req_n;
        int         n_echo;
        int         bad_pos;
        int         stop_at;
        int         lim;
        int         alen;
        int         total;
        int         k;
        logic [7:0] sum;
        logic [7:0] b;
        flaw = (allow_flaws && $urandom_range(99) < 25) ? int'($urandom_range(7)) : -1;
        send_item(make_item(FUNC_START, 8'($urandom), 1'($urandom)));

        // Pure noise: any function with any content.
        if (flaw == 7) begin
            repeat ($urandom_range(4, 12))
                send_item(make_item(2'($urandom), 8'($urandom), 1'($urandom)));
            return;
        end

        // Request; a rare long one runs into the end of the echo store.
        req_n = ($urandom_range(39) == 0) ? int'($urandom_range(20, 66))
                                          : int'($urandom_range(1, 8));
        for (k = 0; k < req_n; k++)
            send_item(make_item(FUNC_SEND, 8'($urandom), (k == req_n - 1) && flaw != 2));
        if (flaw == 3) begin
            repeat ($urandom_range(1, 3))
                send_item(make_item(FUNC_SEND, 8'($urandom), 1'($urandom)));
        end

        // Echo of what went out on the line, possibly corrupted or cut short.
        n_echo  = m_sent;
        bad_pos = (flaw == 0) ? int'($urandom_range(n_echo - 1)) : -1;
        stop_at = (flaw == 1) ? int'($urandom_range(n_echo - 1)) : n_echo;
        for (k = 0; k < stop_at; k++) begin
            b = m_echo_mem[k];
            if (k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
            send_item(make_item(FUNC_RECV, b, 1'($urandom)));
        end
        if (flaw == 1) begin
            send_item(make_item(FUNC_TIMEOUT, 8'($urandom), 1'($urandom)));
            return;
        end
        if (flaw == 2) send_item(make_item(FUNC_RECV, 8'($urandom), 1'($urandom)));
        if (m_phase != PH_ANSWER) return;

        // Answer: dest, length, source, header, data, checksum.
        lim = (m_max_len > DATA_LIMIT) ? int'(DATA_LIMIT) : int'(m_max_len);
        if (flaw == 6) alen = $urandom_range(lim + 1, 255);
        else if ($urandom_range(15) == 0) alen = lim;
        else alen = $urandom_range((lim < 8) ? lim : 8);
        total = alen + int'(ANSWER_OVERHEAD);
        if (flaw == 4) stop_at = $urandom_range(total - 1);
        else if (flaw == 6) stop_at = $urandom_range(2, 6);
        else stop_at = total;
        sum = 8'h00;
        for (k = 0; k < stop_at; k++) begin
            if (k == 1) begin
                b = 8'(alen);
            end else if (k == total - 1) begin
                b = 8'h00 - sum;
                if (flaw == 5) b = b + 8'($urandom_range(1, 255));
            end else begin
                b = 8'($urandom);
            end
            sum = sum + b;
            send_item(make_item(FUNC_RECV, b, 1'($urandom)));
        end
        if (flaw == 4) send_item(make_item(FUNC_TIMEOUT, 8'($urandom), 1'($urandom)));

        // Now and then a stray byte or timeout once the exchange is over.
        if ($urandom_range(3) == 0) begin
            send_item(make_item($urandom_range(1) ? FUNC_RECV : FUNC_TIMEOUT,
                                8'($urandom), 1'($urandom)));
        end
    endtask

    // Hand-picked items at the register reset values.
    task automatic test_directed_cases();
        // Everything but start is ignored while idle.
        send_item(make_item(FUNC_RECV, 8'h00, 1'b0));
        send_item(make_item(FUNC_TIMEOUT, 8'hFF, 1'b1));
        send_item(make_item(FUNC_SEND, 8'hAA, 1'b1));
        // Length byte marked last: the checksum follows it with no source byte.
        send_item(make_item(FUNC_START, 8'h00, 1'b0));
        send_item(make_item(FUNC_SEND, 8'hFF, 1'b0));
        send_item(make_item(FUNC_SEND, 8'h00, 1'b1));
        send_item(make_item(FUNC_RECV, 8'hFF, 1'b0));
        send_item(make_item(FUNC_RECV, 8'h00, 1'b1));
        send_item(make_item(FUNC_RECV, 8'h01, 1'b0));
        // Shortest answer with a zero-sum checksum, then ignored items once complete.
        send_item(make_item(FUNC_RECV, 8'h01, 1'b0));
        send_item(make_item(FUNC_RECV, 8'h00, 1'b0));
        send_item(make_item(FUNC_RECV, 8'h02, 1'b0));
        send_item(make_item(FUNC_RECV, 8'h00, 1'b0));
        send_item(make_item(FUNC_RECV, 8'hFD, 1'b1));
        send_item(make_item(FUNC_RECV, 8'h55, 1'b0));
        send_item(make_item(FUNC_TIMEOUT, 8'h00, 1'b0));
        // A mismatched echo is reported once the frame has echoed; errors then hold.
        send_item(make_item(FUNC_START, 8'hFF, 1'b1));
        send_item(make_item(FUNC_SEND, 8'h00, 1'b1));
        send_item(make_item(FUNC_RECV, 8'h00, 1'b0));
        send_item(make_item(FUNC_RECV, 8'h01, 1'b0));
        send_item(make_item(FUNC_SEND, 8'h12, 1'b0));
        send_item(make_item(FUNC_RECV, 8'h00, 1'b0));
        // A line byte with nothing sent is a wrong echo; a timeout in echo is no echo.
        send_item(make_item(FUNC_START, 8'h00, 1'b0));
        send_item(make_item(FUNC_RECV, 8'h00, 1'b0));
        send_item(make_item(FUNC_START, 8'h00, 1'b0));
        send_item(make_item(FUNC_TIMEOUT, 8'h00, 1'b0));
    endtask

    // Random exchanges at one register setting.
    task automatic test_random_exchanges(int n_items, logic [7:0] src_v, logic [7:0] max_v);
        int first;
        wait_idle();
        write_reg(CFG_SOURCE_ADDRESS, src_v);
        write_reg(CFG_MAX_DATA_LENGTH, max_v);
        first = items_sent;
        while (items_sent - first < n_items) run_exchange(1'b1);
    endtask

    // The receiver holds off long enough for the engine to stall its input.
    task automatic test_output_hold_off();
        hold_req <= ~hold_req;
        repeat (3) run_exchange(1'b0);
    endtask

    // Receiver side: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Compare each output transfer with the oldest predicted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_results_q.size() == 0) begin
                $display("%0t: result expected none actual 0x%0h", $time, o_out);
                mismatches++;
            end else begin
                want_item = frame_results_q.pop_front();
                check_field("line_valid", want_item.line_valid, o_out.line_valid);
                check_field("line_byte", want_item.line_byte, o_out.line_byte);
                check_field("answer_valid", want_item.answer_valid, o_out.answer_valid);
                check_field("answer_byte", want_item.answer_byte, o_out.answer_byte);
                check_field("answer_index", want_item.answer_index, o_out.answer_index);
                check_field("rx_state", want_item.rx_state, o_out.rx_state);
                check_field("error_code", want_item.error_code, o_out.error_code);
                check_field("last", want_item.last, o_out.last);
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, stuck_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        m_src     = SOURCE_ADDRESS_RST;
        m_max_len = MAX_DATA_LENGTH_RST;
        clear_engine();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender rarely idle, receiver mostly stalled.
        snd_idle_pct = 9;
        rcv_idle_pct = 66;
        test_directed_cases();
        test_random_exchanges(225, 8'h00, 8'd58);
        test_random_exchanges(225, 8'hFF, 8'd0);

        // The other way round; an all-ones length limit acts as the data limit.
        snd_idle_pct = 66;
        rcv_idle_pct = 9;
        test_random_exchanges(225, 8'($urandom), 8'hFF);
        test_random_exchanges(225, 8'($urandom), 8'($urandom_range(58)));

        // No idling on either side.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_output_hold_off();
        test_random_exchanges(225, 8'h01, 8'd58);
        test_random_exchanges(225, 8'($urandom), 8'($urandom));

        wait_idle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cfe_pkg.sv
hw/rtl/cfe_front.sv
hw/rtl/cfe_queue.sv
hw/rtl/cctalk_frame_engine_unit.sv
dv/cctalk_frame_engine_unit_tb.sv
